FILE: sv/wfpa_pkg.sv
// ----------------------------------------------------------------------------
// wfpa_pkg: shared types and constants of the worst-fit partition allocator
// Field widths, result codes, and the control word format of the sequencer.
// ----------------------------------------------------------------------------
package wfpa_pkg;

	localparam int MAX_PARTITIONS_DEF = 16;
	localparam int SIZE_BITS_DEF      = 16;

	localparam int OPCODE_W = 2;
	localparam int SIZE_W   = 16;
	localparam int STATUS_W = 2;
	localparam int INDEX_W  = 4;
	localparam int PROC_W   = 16;
	localparam int LEFT_W   = 16;
	localparam int SUM_W    = 20;

	localparam logic [SUM_W-1:0]  SUM_MAX = '1;
	localparam logic [PROC_W-1:0] REQ_MAX = '1;

	typedef enum logic [OPCODE_W-1:0] {
		OP_LOAD  = 2'd0,
		OP_ALLOC = 2'd1,
		OP_CLEAR = 2'd2
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_ALLOC = 2'd1,
		ST_NOFIT = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// datapath actions selected by one control word
	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_ACCEPT,
		ACT_LOAD,
		ACT_SCAN_INIT,
		ACT_SCAN,
		ACT_FINISH,
		ACT_CLEAR,
		ACT_EMIT
	} act_t;

	typedef enum logic [1:0] {
		BR_GOTO,
		BR_DISPATCH,
		BR_WAIT
	} branch_t;

	typedef enum logic [1:0] {
		COND_NONE,
		COND_IN_VALID,
		COND_SCAN_DONE,
		COND_OUT_FREE
	} cond_t;

	typedef enum logic [2:0] {
		STEP_WAIT,
		STEP_DISP,
		STEP_LOAD,
		STEP_SINIT,
		STEP_SCAN,
		STEP_FIN,
		STEP_CLEAR,
		STEP_EMIT
	} step_t;

	typedef struct packed {
		act_t    act;
		branch_t br;
		cond_t   cond;
		logic    gate;
		step_t   target;
	} uword_t;

	typedef struct packed {
		act_t act;
		logic fire;
	} ctrl_t;

	typedef struct packed {
		logic    in_valid;
		logic    scan_done;
		logic    out_free;
		opcode_t op;
	} flags_t;

	function automatic step_t dispatch(input opcode_t op);
		step_t s;
		unique case (op)
			OP_LOAD:  s = STEP_LOAD;
			OP_ALLOC: s = STEP_SINIT;
			OP_CLEAR: s = STEP_CLEAR;
			default:  s = STEP_EMIT;
		endcase
		return s;
	endfunction

endpackage

FILE: sv/worst_fit_partition_allocator_core.sv
// ----------------------------------------------------------------------------
// worst_fit_partition_allocator_core: worst-fit fixed-partition allocator
// Microcoded sequencer driving a table of partitions and fragmentation totals.
// ----------------------------------------------------------------------------
// Usage:
// - input channel (in_valid/in_ready) takes one beat of opcode and size:
//   load appends a partition, allocate searches for the worst fit, clear
//   empties the table and zeroes all counters
// - output channel (out_valid/out_ready) returns exactly one beat per input
//   beat: status, partition index, process number, leftover and both totals
// - steps: load and clear pass from dispatch through their own step to emit,
//   an unused opcode goes from dispatch straight to emit; allocate reads the
//   size memory one entry per cycle through its single registered read port,
//   one entry per partition loaded, before its finish step
// - one item at a time; the next input beat can be taken in the cycle after
//   the previous result is loaded into the output register, even if
//   that result has not yet been taken
// - when the receiver stalls, a finished result holds in the output
//   register and the sequencer waits in its emit step
// - reset empties the table and clears busy bits, counters and totals; no clearing pass
//   is needed, the block is ready on the first cycle after reset
module worst_fit_partition_allocator_core #(
	parameter int MAX_PARTITIONS = wfpa_pkg::MAX_PARTITIONS_DEF,
	parameter int SIZE_BITS      = wfpa_pkg::SIZE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [wfpa_pkg::OPCODE_W-1:0]   opcode,
	input  logic [wfpa_pkg::SIZE_W-1:0]     size,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [wfpa_pkg::STATUS_W-1:0]   status,
	output logic [wfpa_pkg::INDEX_W-1:0]    partition_index,
	output logic [wfpa_pkg::PROC_W-1:0]     process_number,
	output logic [wfpa_pkg::LEFT_W-1:0]     leftover,
	output logic [wfpa_pkg::SUM_W-1:0]      internal_total,
	output logic [wfpa_pkg::SUM_W-1:0]      external_total
);
	import wfpa_pkg::*;

	ctrl_t  ctrl;
	flags_t flags;

	assign in_ready = (ctrl.act == ACT_ACCEPT);

	wfpa_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	wfpa_dpath #(
		.MAX_PARTITIONS (MAX_PARTITIONS),
		.SIZE_BITS      (SIZE_BITS)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctrl            (ctrl),
		.opcode          (opcode),
		.size            (size),
		.out_ready       (out_ready),
		.flags           (flags),
		.in_valid        (in_valid),
		.out_valid       (out_valid),
		.status          (status),
		.partition_index (partition_index),
		.process_number  (process_number),
		.leftover        (leftover),
		.internal_total  (internal_total),
		.external_total  (external_total)
	);

endmodule

FILE: sv/wfpa_useq.sv
// ----------------------------------------------------------------------------
// wfpa_useq: microcode sequencer
// Step counter, control store and branch logic; drives the datapath action.
// ----------------------------------------------------------------------------
module wfpa_useq (
	input  logic             clk,
	input  logic             arst_n,
	input  wfpa_pkg::flags_t flags,
	output wfpa_pkg::ctrl_t  ctrl
);
	import wfpa_pkg::*;

	step_t  step_q;
	step_t  step_nxt;
	uword_t word;
	logic   cond_ok;

	function automatic uword_t ucode(input step_t s);
		uword_t w;
		unique case (s)
			STEP_WAIT:  w = '{ACT_ACCEPT,    BR_WAIT,     COND_IN_VALID,  1'b1, STEP_DISP};
			STEP_DISP:  w = '{ACT_NONE,      BR_DISPATCH, COND_NONE,      1'b0, STEP_WAIT};
			STEP_LOAD:  w = '{ACT_LOAD,      BR_GOTO,     COND_NONE,      1'b0, STEP_EMIT};
			STEP_SINIT: w = '{ACT_SCAN_INIT, BR_GOTO,     COND_NONE,      1'b0, STEP_SCAN};
			STEP_SCAN:  w = '{ACT_SCAN,      BR_WAIT,     COND_SCAN_DONE, 1'b0, STEP_FIN};
			STEP_FIN:   w = '{ACT_FINISH,    BR_GOTO,     COND_NONE,      1'b0, STEP_EMIT};
			STEP_CLEAR: w = '{ACT_CLEAR,     BR_GOTO,     COND_NONE,      1'b0, STEP_EMIT};
			STEP_EMIT:  w = '{ACT_EMIT,      BR_WAIT,     COND_OUT_FREE,  1'b1, STEP_WAIT};
			default:    w = '{ACT_NONE,      BR_GOTO,     COND_NONE,      1'b0, STEP_WAIT};
		endcase
		return w;
	endfunction

	always_comb begin
		word = ucode(step_q);
		unique case (word.cond)
			COND_NONE:      cond_ok = 1'b1;
			COND_IN_VALID:  cond_ok = flags.in_valid;
			COND_SCAN_DONE: cond_ok = flags.scan_done;
			COND_OUT_FREE:  cond_ok = flags.out_free;
			default:        cond_ok = 1'b0;
		endcase
	end

	always_comb begin
		unique case (word.br)
			BR_GOTO:     step_nxt = word.target;
			BR_DISPATCH: step_nxt = dispatch(flags.op);
			BR_WAIT:     step_nxt = cond_ok ? word.target : step_q;
			default:     step_nxt = STEP_WAIT;
		endcase
	end

	always_comb begin
		ctrl.act  = word.act;
		ctrl.fire = word.gate ? cond_ok : 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_WAIT;
		end else begin
			step_q <= step_nxt;
		end
	end

endmodule

FILE: sv/wfpa_dpath.sv
// ----------------------------------------------------------------------------
// wfpa_dpath: allocator datapath
// Partition size memory, busy bits, scan compare unit, totals and result regs.
// ----------------------------------------------------------------------------
module wfpa_dpath #(
	parameter int MAX_PARTITIONS = wfpa_pkg::MAX_PARTITIONS_DEF,
	parameter int SIZE_BITS      = wfpa_pkg::SIZE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  wfpa_pkg::ctrl_t                 ctrl,
	input  logic [wfpa_pkg::OPCODE_W-1:0]   opcode,
	input  logic [wfpa_pkg::SIZE_W-1:0]     size,
	input  logic                            out_ready,
	output wfpa_pkg::flags_t                flags,
	input  logic                            in_valid,
	output logic                            out_valid,
	output logic [wfpa_pkg::STATUS_W-1:0]   status,
	output logic [wfpa_pkg::INDEX_W-1:0]    partition_index,
	output logic [wfpa_pkg::PROC_W-1:0]     process_number,
	output logic [wfpa_pkg::LEFT_W-1:0]     leftover,
	output logic [wfpa_pkg::SUM_W-1:0]      internal_total,
	output logic [wfpa_pkg::SUM_W-1:0]      external_total
);
	import wfpa_pkg::*;

	localparam int IW  = $clog2(MAX_PARTITIONS);
	localparam int CW  = $clog2(MAX_PARTITIONS + 1);
	localparam int FW  = SIZE_BITS + CW;
	localparam int EW  = (FW > SUM_W) ? FW : SUM_W + 1;
	localparam int AW  = ((SIZE_BITS > SUM_W) ? SIZE_BITS : SUM_W) + 1;
	localparam logic [CW-1:0] CNT_FULL = CW'(MAX_PARTITIONS);

	// control state
	logic [CW-1:0]             count_q;
	logic [MAX_PARTITIONS-1:0] busy_q;
	logic [PROC_W-1:0]         req_q;
	logic [SUM_W-1:0]          int_q;
	logic [EW-1:0]             ext_q;     // exact free total, saturated on output
	logic [CW-1:0]             issue_q;
	logic                      cmp_valid_q;
	logic                      found_q;
	logic                      out_valid_q;

	// payload
	logic [SIZE_BITS-1:0]      part_size_q [MAX_PARTITIONS];
	logic [SIZE_BITS-1:0]      rd_size_q;
	logic [IW-1:0]             cmp_idx_q;
	opcode_t                   op_q;
	logic [SIZE_BITS-1:0]      sz_q;
	logic [SIZE_BITS-1:0]      best_left_q;
	logic [SIZE_BITS-1:0]      best_size_q;
	logic [IW-1:0]             best_idx_q;
	status_t                   res_status_q;
	logic [IW-1:0]             res_index_q;
	logic [PROC_W-1:0]         res_proc_q;
	logic [SIZE_BITS-1:0]      res_left_q;
	status_t                   out_status_q;
	logic [INDEX_W-1:0]        out_index_q;
	logic [PROC_W-1:0]         out_proc_q;
	logic [LEFT_W-1:0]         out_left_q;
	logic [SUM_W-1:0]          out_int_q;
	logic [SUM_W-1:0]          out_ext_q;

	logic                      fire_accept, fire_load, fire_init, fire_scan;
	logic                      fire_fin, fire_clear, fire_emit;
	logic                      full, issue, cand, take;
	logic [SIZE_BITS-1:0]      diff;
	logic [PROC_W-1:0]         req_nxt;
	logic [AW-1:0]             int_sum;

	always_comb begin
		fire_accept = ctrl.fire && (ctrl.act == ACT_ACCEPT);
		fire_load   = ctrl.fire && (ctrl.act == ACT_LOAD);
		fire_init   = ctrl.fire && (ctrl.act == ACT_SCAN_INIT);
		fire_scan   = ctrl.fire && (ctrl.act == ACT_SCAN);
		fire_fin    = ctrl.fire && (ctrl.act == ACT_FINISH);
		fire_clear  = ctrl.fire && (ctrl.act == ACT_CLEAR);
		fire_emit   = ctrl.fire && (ctrl.act == ACT_EMIT);

		full    = (count_q == CNT_FULL);
		issue   = (issue_q < count_q);
		diff    = rd_size_q - sz_q;
		cand    = cmp_valid_q && !busy_q[cmp_idx_q] && (rd_size_q != '0)
		          && (rd_size_q >= sz_q);
		// strict greater keeps the lowest index on a tie
		take    = cand && (!found_q || (diff > best_left_q));
		req_nxt = (req_q == REQ_MAX) ? req_q : req_q + PROC_W'(1);
		int_sum = AW'(int_q) + AW'(best_left_q);

		flags.in_valid  = in_valid;
		flags.scan_done = !issue && !cmp_valid_q;
		flags.out_free  = !out_valid_q || out_ready;
		flags.op        = op_q;
	end

	// partition size memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (fire_load && !full) begin
			part_size_q[count_q[IW-1:0]] <= sz_q;
		end
		if (fire_scan && issue) begin
			rd_size_q <= part_size_q[issue_q[IW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			busy_q      <= '0;
			req_q       <= '0;
			int_q       <= '0;
			ext_q       <= '0;
			issue_q     <= '0;
			cmp_valid_q <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire_load && !full) begin
				busy_q[count_q[IW-1:0]] <= 1'b0;
				count_q <= count_q + CW'(1);
				ext_q   <= ext_q + EW'(sz_q);
			end
			if (fire_init) begin
				req_q       <= req_nxt;
				issue_q     <= '0;
				cmp_valid_q <= 1'b0;
				found_q     <= 1'b0;
			end
			if (fire_scan) begin
				if (issue) begin
					issue_q <= issue_q + CW'(1);
				end
				cmp_valid_q <= issue;
				if (take) begin
					found_q <= 1'b1;
				end
			end
			if (fire_fin && found_q) begin
				busy_q[best_idx_q] <= 1'b1;
				int_q <= (int_sum > AW'(SUM_MAX)) ? SUM_MAX : int_sum[SUM_W-1:0];
				ext_q <= ext_q - EW'(best_size_q);
			end
			if (fire_clear) begin
				count_q <= '0;
				busy_q  <= '0;
				req_q   <= '0;
				int_q   <= '0;
				ext_q   <= '0;
			end
			if (fire_emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire_accept) begin
			op_q         <= opcode_t'(opcode);
			sz_q         <= SIZE_BITS'(size);
			res_status_q <= ST_DONE;
			res_index_q  <= '0;
			res_proc_q   <= '0;
			res_left_q   <= '0;
		end
		if (fire_load) begin
			if (full) begin
				res_status_q <= ST_FULL;
			end else begin
				res_index_q <= count_q[IW-1:0];
			end
		end
		if (fire_init) begin
			res_proc_q  <= req_nxt;
			best_left_q <= '0;
			best_size_q <= '0;
			best_idx_q  <= '0;
		end
		if (fire_scan) begin
			cmp_idx_q <= issue_q[IW-1:0];
			if (take) begin
				best_left_q <= diff;
				best_size_q <= rd_size_q;
				best_idx_q  <= cmp_idx_q;
			end
		end
		if (fire_fin) begin
			if (found_q) begin
				res_status_q <= ST_ALLOC;
				res_index_q  <= best_idx_q;
				res_left_q   <= best_left_q;
			end else begin
				res_status_q <= ST_NOFIT;
			end
		end
		if (fire_emit) begin
			out_status_q <= res_status_q;
			out_index_q  <= INDEX_W'(res_index_q);
			out_proc_q   <= res_proc_q;
			out_left_q   <= LEFT_W'(res_left_q);
			out_int_q    <= int_q;
			out_ext_q    <= (ext_q > EW'(SUM_MAX)) ? SUM_MAX : ext_q[SUM_W-1:0];
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = out_status_q;
	assign partition_index = out_index_q;
	assign process_number  = out_proc_q;
	assign leftover        = out_left_q;
	assign internal_total  = out_int_q;
	assign external_total  = out_ext_q;

endmodule
